// ===== hdl/text_console_char_writer_macros.svh =====
// assertion macros for the text console character writer
`ifndef TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CHAR_WRITER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TCW_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw assertion failed");

// next-cycle implication, disabled during reset
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw assertion failed");

`endif

// ===== hdl/tcw_pkg.sv =====
// shared types and constants for the text console character writer
package tcw_pkg;

  typedef logic [15:0] cell_t;
  typedef logic [7:0]  char_t;

  localparam char_t NEWLINE_CODE = 8'h0A;
  localparam char_t BLANK_CODE   = 8'h20;
  localparam char_t ATTR_RESET   = 8'h07;
  localparam cell_t RESET_CELL   = 16'h0720;

  localparam logic REQ_PUT  = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [1:0] REG_TEXT_ATTR = 2'd0;

endpackage

// ===== hdl/text_console_char_writer.sv =====
// text console character writer: screen memory, cursor, newline and scroll handling
// after a put without scroll the next item may enter, a read holds input in its read state,
//   and an item that finds the output register still waiting holds input until it drains
// scroll: a put past the last cell holds input while every cell is swept, one cell per cycle
// reset: synchronous; a clearing pass over all COLUMNS*ROWS cells blanks the screen (attribute 7)
`include "text_console_char_writer_macros.svh"

module text_console_char_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  // item input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              req_type,
  input  tcw_pkg::char_t    char_code,
  input  logic [10:0]       cell_index,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [10:0]       cursor_pos,
  output tcw_pkg::cell_t    cell_value,
  output logic              scrolled,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tcw_pkg::*;

  localparam int CELLS      = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int PW         = ADDR_W + 1;
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int COPY_CELLS = CELLS - COLUMNS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } state_t;

  state_t state;

  // screen memory, one write and one registered read per cycle
  cell_t screen_mem [CELLS];
  cell_t mem_rdata;
  logic  mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t mem_wdata;

  // cursor kept as cell index plus column so newline needs no modulo
  logic [ADDR_W-1:0] cursor;
  logic [COL_W-1:0]  col;
  logic [7:0]        text_attr;

  // sweep counter shared by the clearing pass and the scroll
  logic [ADDR_W-1:0] scan;

  // scroll write stage, writing in the cycle after its read
  logic              wr_valid;
  logic              wr_copy;
  logic [ADDR_W-1:0] wr_addr;

  // held result while the output register is busy
  cell_t res_cell;
  logic  res_scrolled;
  logic  rd_oob;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              start_scroll;
  logic              cfg_wr;
  logic              is_newline;
  logic              need_scroll;
  logic              rd_in_range;
  logic [PW-1:0]     pos_calc;
  logic [ADDR_W-1:0] cursor_next;
  logic [COL_W-1:0]  col_next;
  cell_t             read_val;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign start_scroll = accept && (req_type == REQ_PUT) && need_scroll;

  // output register loads a result this cycle
  assign load_out = out_free &&
                    ((accept && (req_type == REQ_PUT) && !need_scroll) ||
                     (state == ST_READ) || (state == ST_DONE));

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr == REG_TEXT_ATTR) ? {24'b0, text_attr} : '0;

  assign rd_in_range = 32'(cell_index) < 32'(CELLS);
  assign read_val    = rd_oob ? '0 : mem_rdata;

  // cursor advance for a put
  always_comb begin
    is_newline = (char_code == NEWLINE_CODE);
    if (is_newline) begin
      pos_calc = {1'b0, cursor} - PW'(col) + PW'(COLUMNS);
      col_next = '0;
    end else begin
      pos_calc = {1'b0, cursor} + PW'(1);
      col_next = (col == COL_W'(COLUMNS - 1)) ? '0 : col + COL_W'(1);
    end
    need_scroll = (pos_calc >= PW'(CELLS));
    if (need_scroll) begin
      cursor_next = ADDR_W'(pos_calc - PW'(COLUMNS));
    end else begin
      cursor_next = pos_calc[ADDR_W-1:0];
    end
  end

  // read address: source row during scroll, else the requested cell
  always_comb begin
    if (state == ST_SCROLL) begin
      mem_raddr = scan + ADDR_W'(COLUMNS);
    end else begin
      mem_raddr = ADDR_W'(cell_index);
    end
  end

  // write port: scroll stage first, then clearing pass, then a character put
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cursor;
    mem_wdata = {text_attr, char_code};
    priority if (wr_valid) begin
      mem_we    = 1'b1;
      mem_waddr = wr_addr;
      mem_wdata = wr_copy ? mem_rdata : {text_attr, BLANK_CODE};
    end else if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = scan;
      mem_wdata = RESET_CELL;
    end else if (accept && (req_type == REQ_PUT) && !is_newline) begin
      mem_we    = 1'b1;
      mem_waddr = cursor;
      mem_wdata = {text_attr, char_code};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= screen_mem[mem_raddr];
  end

  // sequencer, cursor, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan      <= '0;
      cursor    <= '0;
      col       <= '0;
      text_attr <= ATTR_RESET;
      out_valid <= 1'b0;
      wr_valid  <= 1'b0;
    end else begin
      if (cfg_wr && (paddr == REG_TEXT_ATTR)) begin
        text_attr <= pwdata[7:0];
      end
      // held result stays until taken, a new one loads only into a free register
      out_valid <= load_out || (out_valid && out_stall);
      wr_valid  <= (state == ST_SCROLL);

      unique case (state)
        ST_CLEAR: begin
          if (scan == ADDR_W'(CELLS - 1)) begin
            scan  <= '0;
            state <= ST_IDLE;
          end else begin
            scan <= scan + ADDR_W'(1);
          end
        end

        ST_IDLE: begin
          if (accept) begin
            if (req_type == REQ_READ) begin
              rd_oob <= !rd_in_range;
              state  <= ST_READ;
            end else begin
              cursor       <= cursor_next;
              col          <= col_next;
              res_cell     <= '0;
              res_scrolled <= need_scroll;
              if (need_scroll) begin
                scan  <= '0;
                state <= ST_SCROLL;
              end else if (out_free) begin
                cursor_pos <= 11'(cursor_next);
                cell_value <= '0;
                scrolled   <= 1'b0;
              end else begin
                state <= ST_DONE;
              end
            end
          end
        end

        ST_READ: begin
          if (out_free) begin
            cursor_pos <= 11'(cursor);
            cell_value <= read_val;
            scrolled   <= 1'b0;
            state      <= ST_IDLE;
          end else begin
            res_cell     <= read_val;
            res_scrolled <= 1'b0;
            state        <= ST_DONE;
          end
        end

        ST_SCROLL: begin
          // read cell scan+COLUMNS now, write it to scan next cycle (the bottom row gets blanks)
          wr_addr  <= scan;
          wr_copy  <= (scan < ADDR_W'(COPY_CELLS));
          if (scan == ADDR_W'(CELLS - 1)) begin
            scan  <= '0;
            state <= ST_DONE;
          end else begin
            scan <= scan + ADDR_W'(1);
          end
        end

        ST_DONE: begin
          if (out_free) begin
            cursor_pos <= 11'(cursor);
            cell_value <= res_cell;
            scrolled   <= res_scrolled;
            state      <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // cursor never leaves the screen
  `TCW_ASSERT_IMPL(a_cursor_range, clk, rst, 1'b1, 32'(cursor) < 32'(CELLS))
  // a put past the last cell starts the scroll sweep from the top
  `TCW_ASSERT_NEXT(a_scroll_start, clk, rst, start_scroll, (state == ST_SCROLL) && (scan == '0))
  // copy writes never land in the bottom row
  `TCW_ASSERT_IMPL(a_copy_bound, clk, rst, wr_valid && wr_copy, 32'(wr_addr) < 32'(COPY_CELLS))

endmodule

// ===== bench/text_console_char_checker.sv =====
// result checker for the text console character writer: screen prediction and compare
module text_console_char_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  logic           req_type,
  input  tcw_pkg::char_t char_code,
  input  logic [10:0]    cell_index,
  input  logic           out_valid,
  input  logic           out_stall,
  input  logic [10:0]    cursor_pos,
  input  tcw_pkg::cell_t cell_value,
  input  logic           scrolled,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [1:0]     paddr,
  input  logic [31:0]    pwdata,
  input  logic           pready,
  output int             fail_count,
  output int             pending
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam logic [1:0] ATTR_ADDR = 2'(4 * REG_TEXT_ATTR);

  typedef struct packed {
    logic [10:0] cursor;
    cell_t       cell_data;
    logic        scrolled;
  } console_result_t;

  cell_t           screen_model [CELLS];
  logic [10:0]     cursor_model;
  char_t           attr_model;
  console_result_t expected_results[$];
  int              errors;

  assign fail_count = errors;

  function automatic console_result_t predict_console_item(logic req, char_t ch,
                                                           logic [10:0] idx);
    console_result_t r;
    int pos;
    r = '0;
    if (req == REQ_READ) begin
      if (idx < CELLS) r.cell_data = screen_model[idx];
    end else begin
      pos = cursor_model;
      if (pos >= CELLS) pos = CELLS - 1;
      if (ch == NEWLINE_CODE) begin
        pos = pos - (pos % COLUMNS) + COLUMNS;
      end else begin
        screen_model[pos] = {attr_model, ch};
        pos++;
      end
      // ran off the end: move every row up, blank the bottom row
      if (pos >= CELLS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++)
          screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
          screen_model[i] = {attr_model, BLANK_CODE};
        pos -= COLUMNS;
        r.scrolled = 1'b1;
      end
      cursor_model = 11'(pos);
    end
    r.cursor = cursor_model;
    return r;
  endfunction

  initial errors = 0;

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen_model[i] = RESET_CELL;
      cursor_model = '0;
      attr_model = ATTR_RESET;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ATTR_ADDR)
        attr_model = pwdata[7:0];
      if (in_valid && !in_stall)
        expected_results.push_back(predict_console_item(req_type, char_code, cell_index));
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result cursor %0d cell %h scrolled %0d",
                     $realtime, cursor_pos, cell_value, scrolled);
        end else begin
          want = expected_results.pop_front();
          if (cursor_pos !== want.cursor || cell_value !== want.cell_data ||
              scrolled !== want.scrolled) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch expected cursor %0d cell %h scrolled %0d, got %0d %h %0d",
                       $realtime, want.cursor, want.cell_data, want.scrolled,
                       cursor_pos, cell_value, scrolled);
          end
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// ===== bench/text_console_char_writer_tb.sv =====
// testbench top for the text console character writer: stimulus, idling and verdict
module text_console_char_writer_tb;
  import tcw_pkg::*;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = COLUMNS * ROWS;
  localparam logic [1:0] ATTR_ADDR = 2'(4 * REG_TEXT_ATTR);
  // the limit outlasts a scroll, the clearing pass after reset and the long receiver
  // hold of LONG_HOLD, the longest stretches without a handshake
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 500;
  localparam int PHASE_ITEMS    = 288;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        req_type;
  char_t       char_code;
  logic [10:0] cell_index;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] cursor_pos;
  cell_t       cell_value;
  logic        scrolled;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int idle_cycles;
  int results_taken;
  bit back_to_back;

  text_console_char_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .char_code(char_code), .cell_index(cell_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .cursor_pos(cursor_pos), .cell_value(cell_value), .scrolled(scrolled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  text_console_char_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) result_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .char_code(char_code), .cell_index(cell_index),
    .out_valid(out_valid), .out_stall(out_stall),
    .cursor_pos(cursor_pos), .cell_value(cell_value), .scrolled(scrolled),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // offer one item after a random gap, hold it until the block takes it
  task automatic send_item(input logic req, input char_t ch, input logic [10:0] idx);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= req;
    char_code  <= ch;
    cell_index <= idx;
    do @(posedge clk); while (in_stall);
  endtask

  // sender pauses until every expected result is back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write with a setup and an access phase, only with the block idle
  task automatic write_attr(input char_t value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // stimulus
  initial begin
    int    sel;
    char_t ch;
    logic [10:0] idx;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_PUT;
    char_code  <= '0;
    cell_index <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    back_to_back = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset contents: first and last cell, reads past the screen come back zero
    send_item(REQ_READ, '0, 11'd0);
    send_item(REQ_READ, '0, 11'(CELLS - 1));
    send_item(REQ_READ, '0, 11'(CELLS));
    send_item(REQ_READ, '0, 11'h7FF);
    // extreme characters, a newline mid-row, a blank, a plain control code
    send_item(REQ_PUT, 8'h00, '0);
    send_item(REQ_PUT, 8'hFF, '0);
    send_item(REQ_PUT, NEWLINE_CODE, '0);
    send_item(REQ_PUT, BLANK_CODE, '0);
    send_item(REQ_PUT, 8'h0B, '0);
    send_item(REQ_READ, '0, 11'd0);
    send_item(REQ_READ, '0, 11'd1);
    send_item(REQ_READ, '0, 11'(COLUMNS));
    // full attribute byte
    write_attr(8'hFF);
    send_item(REQ_PUT, 8'h5A, '0);
    send_item(REQ_PUT, 8'h09, '0);
    send_item(REQ_READ, '0, 11'(COLUMNS + 1));
    send_item(REQ_READ, '0, 11'(COLUMNS + 2));
    // empty attribute byte
    write_attr(8'h00);
    send_item(REQ_PUT, 8'h80, '0);
    send_item(REQ_PUT, NEWLINE_CODE, '0);
    send_item(REQ_PUT, 8'h7F, '0);
    send_item(REQ_READ, '0, 11'(COLUMNS + 3));
    send_item(REQ_READ, '0, 11'(2 * COLUMNS));
    send_item(REQ_READ, '0, 11'd1024);

    // random phases, one attribute setting each; newlines are frequent so the
    // cursor soon sits on the bottom row and newlines then scroll
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        1:       write_attr(8'h00);
        2:       write_attr(8'hFF);
        default: write_attr(char_t'($urandom_range(0, 255)));
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // stretches where the sender never idles
        if (i % 40 == 0) back_to_back = ($urandom_range(0, 3) == 0);
        sel = $urandom_range(0, 99);
        if (sel < 25) begin
          sel = $urandom_range(0, 9);
          if (sel < 5)      idx = 11'($urandom_range(0, 2047));
          else if (sel < 8) idx = 11'($urandom_range(CELLS - 2 * COLUMNS, CELLS - 1));
          else              idx = 11'($urandom_range(0, COLUMNS - 1));
          send_item(REQ_READ, char_t'($urandom_range(0, 255)), idx);
        end else begin
          ch = ($urandom_range(0, 99) < 12) ? NEWLINE_CODE : char_t'($urandom_range(0, 255));
          send_item(REQ_PUT, ch, 11'($urandom_range(0, 2047)));
        end
      end
    end
    back_to_back = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // receiver: random stall before each item, some stretches without stalls,
  // and two long holds so the block backs up and stalls its input
  initial begin
    int  hold;
    bit  no_stall;
    results_taken = 0;
    no_stall = 1'b0;
    forever begin
      if (results_taken % 50 == 0) no_stall = ($urandom_range(0, 3) == 0);
      if (results_taken == 150 || results_taken == 650) hold = LONG_HOLD;
      else if (no_stall)                                  hold = 0;
      else                                                hold = $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      results_taken++;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/tcw_pkg.sv
hdl/text_console_char_writer.sv
bench/text_console_char_checker.sv
bench/text_console_char_writer_tb.sv
